// File: design/sd_spi_command_issue_defines.svh
// Assertion macros used by the command issuer's byte emitter.
`ifndef SD_SPI_COMMAND_ISSUE_DEFINES_SVH
`define SD_SPI_COMMAND_ISSUE_DEFINES_SVH

`ifndef SYNTHESIS
`define SDCI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sdci assertion failed");
`define SDCI_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sdci assertion failed during or after reset");
`else
`define SDCI_ASSERT(lbl, prop)
`define SDCI_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: design/sdci_pkg.sv
// Shared types, constants and the CRC7 byte update of the command issuer.
package sdci_pkg;

  localparam logic [5:0] APP_PREFIX_IDX = 6'd55;
  localparam logic [1:0] FRAME_START    = 2'b01;
  localparam logic [6:0] CRC_POLY       = 7'h09;
  localparam logic [7:0] TRIES_RESET    = 8'd10;
  localparam logic [2:0] FRAME_LAST     = 3'd5;
  localparam logic       KIND_TX        = 1'b0;
  localparam logic       KIND_RESP      = 1'b1;

  // Work handed from the sequencer to the byte emitter.
  typedef struct packed {
    logic        valid;
    logic        resp;   // single response byte rather than a frame
    logic [5:0]  index;
    logic [31:0] arg;
    logic [7:0]  rx;
  } job_t;

  function automatic logic [6:0] crc7_feed(input logic [6:0] crc_in, input logic [7:0] data_in);
    logic [6:0] c;
    logic [7:0] d;
    logic       fb;
    c = crc_in;
    d = data_in;
    for (int k = 0; k < 8; k++) begin
      fb = d[7] ^ c[6];
      c  = {c[5:0], 1'b0} ^ (fb ? CRC_POLY : 7'h00);
      d  = {d[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: design/sdci_seq.sv
// Command sequencer: phase, pending command, response tries and the tries register.
module sdci_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wdata,
  input  logic                in_fire,
  input  logic                in_cmd,
  input  logic [5:0]          in_command_index,
  input  logic                in_application_command,
  input  logic [31:0]         in_argument,
  input  logic [7:0]          in_received_byte,
  output sdci_pkg::job_t      job
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PREFIX  = 2'd1,
    PH_COMMAND = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [5:0]  pend_idx_r, pend_idx_nxt;
  logic [31:0] pend_arg_r, pend_arg_nxt;
  logic [7:0]  tries_r, tries_nxt;
  logic [7:0]  resp_tries_r;
  logic [7:0]  reload;
  logic [7:0]  tries_dec;
  logic        waiting;

  assign reload    = (resp_tries_r != 8'd0) ? resp_tries_r : 8'd1;
  assign tries_dec = (tries_r != 8'd0) ? tries_r - 8'd1 : 8'd0;

  always_comb begin
    phase_nxt    = phase_r;
    pend_idx_nxt = pend_idx_r;
    pend_arg_nxt = pend_arg_r;
    tries_nxt    = tries_r;
    job          = '0;
    waiting      = (phase_r == PH_PREFIX) || (phase_r == PH_COMMAND);
    if (in_fire) begin
      if (!in_cmd) begin
        // new command abandons anything pending
        pend_idx_nxt = in_command_index;
        pend_arg_nxt = in_argument;
        tries_nxt    = reload;
        job.valid    = 1'b1;
        if (in_application_command) begin
          phase_nxt = PH_PREFIX;
          job.index = sdci_pkg::APP_PREFIX_IDX;
          job.arg   = '0;
        end else begin
          phase_nxt = PH_COMMAND;
          job.index = in_command_index;
          job.arg   = in_argument;
        end
      end else if (!waiting) begin
        phase_nxt = PH_IDLE;
      end else begin
        tries_nxt = tries_dec;
        priority if (in_received_byte[7] && tries_dec != 8'd0) begin
          // busy byte, keep scanning
        end else if (phase_r == PH_PREFIX && in_received_byte <= 8'd1) begin
          phase_nxt = PH_COMMAND;
          tries_nxt = reload;
          job.valid = 1'b1;
          job.index = pend_idx_r;
          job.arg   = pend_arg_r;
        end else begin
          phase_nxt = PH_IDLE;
          job.valid = 1'b1;
          job.resp  = 1'b1;
          job.rx    = in_received_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      pend_idx_r   <= '0;
      pend_arg_r   <= '0;
      tries_r      <= '0;
      resp_tries_r <= sdci_pkg::TRIES_RESET;
    end else begin
      phase_r    <= phase_nxt;
      pend_idx_r <= pend_idx_nxt;
      pend_arg_r <= pend_arg_nxt;
      tries_r    <= tries_nxt;
      if (cfg_wr_en) begin
        resp_tries_r <= cfg_wdata;
      end
    end
  end

endmodule

// File: design/sdci_emit.sv
// Byte emitter: walks a frame or a response out through the output register.
`include "sd_spi_command_issue_defines.svh"

module sdci_emit (
  input  logic           clk,
  input  logic           rst_n,
  input  sdci_pkg::job_t job,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_kind,
  output logic [7:0]     out_byte,
  output logic           out_last
);

  logic        busy_r;
  logic        resp_r;
  logic [2:0]  cnt_r;
  logic [5:0]  idx_r;
  logic [31:0] arg_r;
  logic [7:0]  rx_r;
  logic [6:0]  crc_r, crc_nxt;
  logic        out_valid_r;
  logic        out_kind_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;
  logic        adv;
  logic        last_beat;
  logic [7:0]  byte_sel;

  assign adv       = busy_r && (!out_valid_r || out_ready);
  assign last_beat = resp_r || (cnt_r == sdci_pkg::FRAME_LAST);
  assign in_ready  = !busy_r || (adv && last_beat);

  always_comb begin
    if (resp_r) begin
      byte_sel = rx_r;
    end else begin
      unique case (cnt_r)
        3'd0:    byte_sel = {sdci_pkg::FRAME_START, idx_r};
        3'd1:    byte_sel = arg_r[31:24];
        3'd2:    byte_sel = arg_r[23:16];
        3'd3:    byte_sel = arg_r[15:8];
        3'd4:    byte_sel = arg_r[7:0];
        default: byte_sel = {crc_r, 1'b1};
      endcase
    end
    crc_nxt = crc_r;
    if (job.valid) begin
      crc_nxt = '0;
    end else if (adv && !last_beat) begin
      crc_nxt = sdci_pkg::crc7_feed(crc_r, byte_sel);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      // a new job may land on the beat that finishes the old one
      if (job.valid) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (adv) begin
        cnt_r <= cnt_r + 3'd1;
        if (last_beat) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    if (job.valid) begin
      resp_r <= job.resp;
      idx_r  <= job.index;
      arg_r  <= job.arg;
      rx_r   <= job.rx;
    end
    if (adv) begin
      out_kind_r <= resp_r ? sdci_pkg::KIND_RESP : sdci_pkg::KIND_TX;
      out_byte_r <= byte_sel;
      out_last_r <= last_beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  `SDCI_ASSERT(a_cnt_range, busy_r && !resp_r |-> cnt_r <= sdci_pkg::FRAME_LAST)
  `SDCI_ASSERT(a_resp_single, busy_r && resp_r |-> cnt_r == 3'd0)
  `SDCI_ASSERT(a_done_idle, adv && last_beat && !job.valid |=> !busy_r)
  `SDCI_ASSERT_ALWAYS(a_job_needs_room, job.valid |-> in_ready)

endmodule

// File: design/sd_spi_command_issue.sv
// SD-card SPI-mode command issuer. An issue beat (cmd 0) starts a six-byte command frame
// (start byte, argument most significant byte first, CRC7 with stop bit), preceded by
// command 55 when application_command is set; a receive beat (cmd 1) feeds one card byte to
// the response scan, which reports the first byte with bit 7 clear, or the last byte once
// response_tries bytes have been scanned, as the R1 response; after command 55 a byte of 0
// or 1 sends the pending frame instead. A frame leaves as six beats on the result channel,
// one per cycle unless out_ready holds them, the last marked; a response is one beat. The
// sequencer settles each input beat in the cycle it is taken; while a frame or response
// goes out, no new input beat is taken until its last byte is registered. The CRC is built
// a byte at a time as the frame goes out. response_tries resets to 10; zero acts as one.
module sd_spi_command_issue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_response_tries,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [5:0]  in_command_index,
  input  logic        in_application_command,
  input  logic [31:0] in_argument,
  input  logic [7:0]  in_received_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  sdci_pkg::job_t job;
  logic           in_fire;

  assign in_fire = in_valid && in_ready;

  sdci_seq u_seq (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wdata              (cfg_response_tries),
    .in_fire                (in_fire),
    .in_cmd                 (in_cmd),
    .in_command_index       (in_command_index),
    .in_application_command (in_application_command),
    .in_argument            (in_argument),
    .in_received_byte       (in_received_byte),
    .job                    (job)
  );

  sdci_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the SD-card SPI-mode command issuer.
`timescale 1ns / 100ps

module tb_top;

  localparam logic CMD_ISSUE = 1'b0;
  localparam logic CMD_RX    = 1'b1;
  localparam int   IDLE_PCT  = 13;
  localparam int   MAX_SHOWN = 10;
  localparam int   SETTLE    = 12;

  typedef enum logic [1:0] {PH_IDLE, PH_PREFIX, PH_COMMAND} sd_phase_t;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  index;
    logic        app;
    logic [31:0] arg;
    logic [7:0]  rx;
  } exch_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_response_tries = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_kind;
  logic [7:0]  out_byte;
  logic        out_last;
  exch_t       cur_item = '0;

  // Own copy of the issuer state
  logic [7:0]  tries_cfg = sdci_pkg::TRIES_RESET;
  sd_phase_t   phase = PH_IDLE;
  logic [5:0]  pend_idx = '0;
  logic [31:0] pend_arg = '0;
  logic [7:0]  tries_left = '0;

  exch_t pending_exch[$];
  beat_t due_beats[$];

  int    n_in_acc = 0;
  int    n_pushed = 0;
  int    n_mismatch = 0;
  logic  stall_req = 1'b0;
  logic  stall_done = 1'b0;
  int    stall_cnt = 0;
  logic  calm;
  beat_t got_beat;
  beat_t want_beat;

  assign calm = (n_in_acc >= 70) && (n_in_acc < 110);

  sd_spi_command_issue DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_response_tries     (cfg_response_tries),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_cmd                 (cur_item.cmd),
    .in_command_index       (cur_item.index),
    .in_application_command (cur_item.app),
    .in_argument            (cur_item.arg),
    .in_received_byte       (cur_item.rx),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_kind               (out_kind),
    .out_byte               (out_byte),
    .out_last               (out_last)
  );

  always #2 clk = ~clk;

  function automatic logic [6:0] crc7_step(input logic [6:0] c, input logic [7:0] d);
    logic [6:0] r;
    logic [7:0] s;
    int         k;
    r = c;
    s = d;
    for (k = 0; k < 8; k++) begin
      if (s[7] ^ r[6]) begin
        r = {r[5:0], 1'b0} ^ sdci_pkg::CRC_POLY;
      end else begin
        r = {r[5:0], 1'b0};
      end
      s = {s[6:0], 1'b0};
    end
    return r;
  endfunction

  function automatic void queue_frame(input logic [5:0] idx, input logic [31:0] arg);
    logic [7:0] fbytes [0:4];
    logic [6:0] crc;
    int         k;
    fbytes[0] = {sdci_pkg::FRAME_START, idx};
    fbytes[1] = arg[31:24];
    fbytes[2] = arg[23:16];
    fbytes[3] = arg[15:8];
    fbytes[4] = arg[7:0];
    crc = '0;
    for (k = 0; k < 5; k++) begin
      crc = crc7_step(crc, fbytes[k]);
      due_beats.push_back(beat_t'{sdci_pkg::KIND_TX, fbytes[k], 1'b0});
    end
    due_beats.push_back(beat_t'{sdci_pkg::KIND_TX, {crc, 1'b1}, 1'b1});
    tries_left = (tries_cfg != 8'd0) ? tries_cfg : 8'd1;
  endfunction

  function automatic void predict_exchange(input exch_t x);
    if (x.cmd == CMD_ISSUE) begin
      // a new issue abandons whatever was awaited
      pend_idx = x.index;
      pend_arg = x.arg;
      if (x.app) begin
        phase = PH_PREFIX;
        queue_frame(sdci_pkg::APP_PREFIX_IDX, 32'd0);
      end else begin
        phase = PH_COMMAND;
        queue_frame(x.index, x.arg);
      end
    end else if (phase != PH_IDLE) begin
      if (tries_left != 8'd0) tries_left = tries_left - 8'd1;
      if (!x.rx[7] || tries_left == 8'd0) begin
        if (phase == PH_PREFIX && x.rx <= 8'd1) begin
          phase = PH_COMMAND;
          queue_frame(pend_idx, pend_arg);
        end else begin
          phase = PH_IDLE;
          due_beats.push_back(beat_t'{sdci_pkg::KIND_RESP, x.rx, 1'b1});
        end
      end
    end
  endfunction

  // Driver: offer pending beats, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_exchange(cur_item);
        n_in_acc <= n_in_acc + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_exch.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          cur_item <= pending_exch.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure, with one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_cnt  <= 0;
      stall_done <= 1'b0;
    end else if (stall_cnt != 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ready <= 1'b0;
    end else if (stall_req && !stall_done) begin
      stall_cnt  <= 400;
      stall_done <= 1'b1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_beat = beat_t'{out_kind, out_byte, out_last};
      if (due_beats.size() == 0) begin
        if (n_mismatch < MAX_SHOWN)
          $display("unexpected beat: kind %0d byte %02h last %0d",
                   got_beat.kind, got_beat.data, got_beat.last);
        n_mismatch++;
      end else begin
        want_beat = due_beats.pop_front();
        if (got_beat !== want_beat) begin
          if (n_mismatch < MAX_SHOWN)
            $display("mismatch: kind %0d/%0d byte %02h/%02h last %0d/%0d (exp/act)",
                     want_beat.kind, got_beat.kind, want_beat.data, got_beat.data,
                     want_beat.last, got_beat.last);
          n_mismatch++;
        end
      end
    end
  end

  task automatic push_issue(input logic [5:0] idx, input logic app, input logic [31:0] arg);
    pending_exch.push_back(exch_t'{CMD_ISSUE, idx, app, arg, 8'($urandom)});
    n_pushed++;
  endtask

  task automatic push_rx(input logic [7:0] b);
    pending_exch.push_back(exch_t'{CMD_RX, 6'($urandom), 1'($urandom), $urandom, b});
    n_pushed++;
  endtask

  // Hold until every beat is in and every prediction has been met
  task automatic wait_idle();
    while (pending_exch.size() != 0 || in_valid || due_beats.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_tries(input logic [7:0] v);
    wait_idle();
    cfg_response_tries <= v;
    cfg_wr_en          <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tries_cfg = v;
  endtask

  // Busy bytes, then an R1 unless the scan runs out
  task automatic push_reply(input logic [7:0] tries, input logic prefix, output logic passed);
    int         eff;
    int         busy;
    int         k;
    logic [7:0] r1;
    eff    = (tries == 8'd0) ? 1 : int'(tries);
    busy   = $urandom_range((eff < 8) ? eff : 8);
    passed = 1'b0;
    for (k = 0; k < busy && k < eff; k++) push_rx(8'h80 | 8'($urandom_range(127)));
    if (busy < eff) begin
      if (prefix && $urandom_range(99) < 70) r1 = 8'($urandom_range(1));
      else r1 = 8'($urandom_range(127));
      push_rx(r1);
      passed = prefix && (r1 <= 8'd1);
    end
  endtask

  task automatic push_random(input int target);
    int   r;
    logic app;
    logic passed;
    n_pushed = 0;
    while (n_pushed < target) begin
      r = $urandom_range(99);
      if (r < 12) begin
        push_rx(8'($urandom));
      end else begin
        app = ($urandom_range(99) < 35);
        push_issue(6'($urandom), app, $urandom);
        // drop the reply now and then, so the next issue cuts in
        if (r >= 20) begin
          push_reply(tries_cfg, app, passed);
          if (passed) push_reply(tries_cfg, 1'b0, passed);
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset tries: stray byte, plain, extremes, prefix paths, cut-in issues
    push_rx(8'h5A);
    push_issue(6'd0, 1'b0, 32'h0000_0000);
    push_rx(8'hFF); push_rx(8'h80); push_rx(8'h00);
    push_issue(6'd63, 1'b0, 32'hFFFF_FFFF);
    push_rx(8'h01);
    push_issue(6'd41, 1'b1, 32'hA5A5_5A5A);
    push_rx(8'h01); push_rx(8'hFE); push_rx(8'h7F);
    push_issue(6'd13, 1'b1, 32'h0000_0000);
    push_rx(8'h05);
    push_issue(6'd8, 1'b0, 32'h0000_01AA);
    push_issue(6'd9, 1'b0, 32'h8000_0001);
    push_rx(8'h00);
    push_issue(6'd6, 1'b1, 32'h0000_0002);
    push_rx(8'h00);
    push_issue(6'd2, 1'b0, 32'h1234_5678);
    push_rx(8'h00);
    push_rx(8'hFF);

    // zero tries acts as one: every busy byte times out
    write_tries(8'd0);
    push_issue(6'd17, 1'b0, 32'h1234_5678);
    push_rx(8'hC3);
    push_issue(6'd23, 1'b1, 32'hDEAD_BEEF);
    push_rx(8'h80);
    push_rx(8'h00);

    write_tries(8'd3);
    push_issue(6'd24, 1'b0, 32'h0F0F_F0F0);
    push_rx(8'hFF); push_rx(8'hFF); push_rx(8'hFF);
    push_issue(6'd51, 1'b1, 32'h7FFF_FFFE);
    push_rx(8'h80); push_rx(8'h81); push_rx(8'h01);
    push_rx(8'h00);

    // random phases; the first one takes the long receiver hold-off
    write_tries(8'd1);
    push_random(30);
    stall_req = 1'b1;

    write_tries(8'd255);
    push_random(20);

    write_tries(8'($urandom_range(6, 2)));
    push_random(35);

    wait_idle();
    if (n_mismatch == 0 && due_beats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/sdci_pkg.sv
design/sdci_seq.sv
design/sdci_emit.sv
design/sd_spi_command_issue.sv
tb/tb_top.sv
